/* rtl/ipv_pkg.sv */
// Package for the address text validator: item types, parse modes, constants.
// Used by every module under rtl; no dependencies.
package ipv_pkg;

    localparam logic [3:0] GAP_NONE = 4'd15;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        MODE_UNDECIDED = 2'd0,
        MODE_V4        = 2'd1,
        MODE_V6        = 2'd2,
        MODE_TAIL      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PC_NONE   = 2'd0,
        PC_SINGLE = 2'd1,
        PC_DOUBLE = 2'd2
    } colon_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic        valid_res;
        logic        is_v6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } out_item_t;

    // Classified character, front to back.
    typedef struct packed {
        logic       is_dec;
        logic       is_hex;
        logic       is_dot;
        logic       is_colon;
        logic       is_zero;
        logic [3:0] val;
        logic       last;
    } cls_t;

endpackage

/* rtl/ip_address_text_validator.sv */
// Top level of the address text validator: front classify, queue, back parse.
// Depends on ipv_pkg, ipv_front, ipv_queue, ipv_back.
//
// Usage: feed the address text one character per item on in_item
// (ch, last) with in_valid; the block stalls via in_stall. Set last on the
// final character. For each string one result item leaves on out_item with
// out_valid; hold out_stall high to make it wait.
// Throughput: one character per cycle while out_stall is low, with no gap between strings;
// the back parser advances one character per clock unless a stalled result holds it.
// The last accepted character passes the classify register, then a queue slot,
// and is parsed into the result register, where out_valid rises.
// Reset: all parse state clears, no result is pending, the queue empties.
// Stall: a stalled result holds in the output register and the back parser
// pauses; the queue and the classify register fill, then in_stall rises.
// Nothing is dropped.
// IPv4 text is reported as the mapped address ::ffff:a.b.c.d; an invalid
// string yields zero address bits.
module ip_address_text_validator
    import ipv_pkg::*;
#(
    parameter int QDepth = QueueDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic      in_valid,
    output logic      in_stall,
    output out_item_t out_item,
    output logic      out_valid,
    input  logic      out_stall
);
    cls_t f_cls, q_cls;
    logic f_vld, f_stl, q_vld, q_stl;

    ipv_front u_front (
        .clk, .rst_n, .in_item, .in_valid, .in_stall,
        .cls(f_cls), .cls_valid(f_vld), .cls_stall(f_stl)
    );

    ipv_queue #(.Depth(QDepth)) u_queue (
        .clk, .rst_n,
        .wr_data(f_cls), .wr_valid(f_vld), .wr_stall(f_stl),
        .rd_data(q_cls), .rd_valid(q_vld), .rd_stall(q_stl)
    );

    ipv_back u_back (
        .clk, .rst_n, .cls(q_cls), .cls_valid(q_vld), .cls_stall(q_stl),
        .out_item, .out_valid, .out_stall
    );
endmodule

/* rtl/ipv_front.sv */
// Front part: accepts characters and classifies them into digit/separator codes.
// Depends on ipv_pkg.
module ipv_front
    import ipv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_item_t in_item,
    input  logic     in_valid,
    output logic     in_stall,
    output cls_t     cls,
    output logic     cls_valid,
    input  logic     cls_stall
);
    cls_t cls_reg, cls_next;
    logic vld_reg;
    logic [7:0] c;

    assign in_stall = vld_reg && cls_stall;
    assign c = in_item.ch;

    always_comb
    begin
        cls_next.is_dec   = (c >= 8'h30) && (c <= 8'h39);
        cls_next.is_hex   = cls_next.is_dec || ((c >= 8'h61) && (c <= 8'h66))
                            || ((c >= 8'h41) && (c <= 8'h46));
        cls_next.is_dot   = (c == 8'h2e);
        cls_next.is_colon = (c == 8'h3a);
        cls_next.is_zero  = (c == 8'h30);
        if (cls_next.is_dec)
            cls_next.val = c[3:0];
        else
            cls_next.val = c[3:0] + 4'd9;
        cls_next.last = in_item.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (!in_stall)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            cls_reg <= cls_next;
    end

    assign cls       = cls_reg;
    assign cls_valid = vld_reg;
endmodule

/* rtl/ipv_queue.sv */
// Short FIFO between the classify front and the parse back.
// Depends on ipv_pkg.
module ipv_queue
    import ipv_pkg::*;
#(
    parameter int Depth = QueueDepth
)
(
    input  logic clk,
    input  logic rst_n,
    input  cls_t wr_data,
    input  logic wr_valid,
    output logic wr_stall,
    output cls_t rd_data,
    output logic rd_valid,
    input  logic rd_stall
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    cls_t mem [Depth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic wr, rd;

    assign wr_stall = (cnt_reg == (AW+1)'(Depth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(Depth-1)) ? '0 : wp_reg + 1'b1;
            if (rd)
                rp_reg <= (rp_reg == AW'(Depth-1)) ? '0 : rp_reg + 1'b1;
            if (wr && !rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end
endmodule

/* rtl/ipv_back.sv */
// Back part: parse state machine per character, verdict and address on last.
// Depends on ipv_pkg.
module ipv_back
    import ipv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cls_t      cls,
    input  logic      cls_valid,
    output logic      cls_stall,
    output out_item_t out_item,
    output logic      out_valid,
    input  logic      out_stall
);
    logic [15:0] grp_reg [8];
    logic [15:0] grp_next [8];
    logic [3:0]  gcnt_reg, gcnt_next;
    logic [3:0]  gap_reg, gap_next;
    logic [16:0] hex_reg, hex_next;
    logic [8:0]  dec_reg, dec_next;
    logic [1:0]  run_reg, run_next;
    logic        rz_reg, rz_next;
    logic        let_reg, let_next;
    logic [7:0]  oct_reg [3];
    logic [7:0]  oct_next [3];
    logic [2:0]  oidx_reg, oidx_next;
    mode_t       mode_reg, mode_next;
    colon_t      pc_reg, pc_next;
    logic        fail_reg, fail_next;
    out_item_t   res_reg, res_next;
    logic        ovld_reg;
    logic        take;

    assign cls_stall = ovld_reg && out_stall;
    assign take      = cls_valid && !cls_stall;
    assign out_item  = res_reg;
    assign out_valid = ovld_reg;

    function automatic logic oct_ok(logic [1:0] run, logic lt, logic [8:0] d, logic rz);
        return (run != 2'd0) && !lt && (d <= 9'd255) && !((run > 2'd1) && rz);
    endfunction

    logic [20:0] hmul;
    logic [12:0] dmul;
    logic        ok, endg_ok, fin_ok;
    logic [15:0] g [8];
    logic [15:0] fg [8];
    logic [3:0]  fcnt, shift, src;
    logic [7:0]  o3;

    always_comb
    begin
        for (int k = 0; k < 8; k++) grp_next[k] = grp_reg[k];
        for (int k = 0; k < 3; k++) oct_next[k] = oct_reg[k];
        gcnt_next = gcnt_reg; gap_next = gap_reg; hex_next = hex_reg;
        dec_next = dec_reg; run_next = run_reg; rz_next = rz_reg;
        let_next = let_reg; oidx_next = oidx_reg; mode_next = mode_reg;
        pc_next = pc_reg; fail_next = fail_reg;
        hmul = {hex_reg, 4'd0} + 21'(cls.val);
        dmul = 13'({dec_reg, 3'd0}) + 13'({dec_reg, 1'b0}) + 13'(cls.val);
        endg_ok = (run_reg != 2'd0) && (hex_reg <= 17'hFFFF) && (gcnt_reg < 4'd8);
        ok = oct_ok(run_reg, let_reg, dec_reg, rz_reg);

        if (!fail_reg)
        begin
            if (cls.is_hex)
            begin
                if ((mode_reg == MODE_V4 || mode_reg == MODE_TAIL) && !cls.is_dec)
                    fail_next = 1'b1;
                else if (mode_reg == MODE_V6 && (gcnt_reg >= 4'd8 ||
                         (pc_reg == PC_SINGLE && gcnt_reg == 4'd0 && gap_reg == GAP_NONE)))
                    fail_next = 1'b1;
                else
                begin
                    if (mode_reg == MODE_V6) pc_next = PC_NONE;
                    if (run_reg == 2'd0) rz_next = cls.is_zero;
                    if (run_reg != 2'd3) run_next = run_reg + 2'd1;
                    hex_next = (hmul > 21'h10000) ? 17'h10000 : hmul[16:0];
                    if (cls.is_dec)
                        dec_next = (dmul > 13'd256) ? 9'd256 : dmul[8:0];
                    else
                        let_next = 1'b1;
                end
            end
            else if (cls.is_dot)
            begin
                if (mode_reg == MODE_UNDECIDED)
                begin
                    if (!ok) fail_next = 1'b1;
                    else
                    begin
                        oct_next[0] = dec_reg[7:0]; oidx_next = 3'd1; mode_next = MODE_V4;
                    end
                end
                else if (mode_reg == MODE_V6)
                begin
                    if (run_reg == 2'd0 || hex_reg > 17'hFFFF ||
                        (gap_reg == GAP_NONE && gcnt_reg != 4'd6) || gcnt_reg > 4'd6 || !ok)
                        fail_next = 1'b1;
                    else
                    begin
                        oct_next[0] = dec_reg[7:0]; oidx_next = 3'd1; mode_next = MODE_TAIL;
                    end
                end
                else
                begin
                    if (!ok || oidx_reg >= 3'd3) fail_next = 1'b1;
                    else
                    begin
                        oct_next[oidx_reg[1:0]] = dec_reg[7:0];
                        oidx_next = oidx_reg + 3'd1;
                    end
                end
                if (!fail_next)
                begin
                    hex_next = '0; dec_next = '0; run_next = '0; rz_next = 1'b0;
                    let_next = 1'b0;
                end
            end
            else if (cls.is_colon)
            begin
                if (mode_reg == MODE_UNDECIDED || mode_reg == MODE_V6)
                begin
                    if (mode_reg == MODE_UNDECIDED) mode_next = MODE_V6;
                    if (run_reg != 2'd0)
                    begin
                        if (!endg_ok) fail_next = 1'b1;
                        else
                        begin
                            grp_next[gcnt_reg[2:0]] = hex_reg[15:0];
                            gcnt_next = gcnt_reg + 4'd1;
                            hex_next = '0; dec_next = '0; run_next = '0;
                            rz_next = 1'b0; let_next = 1'b0;
                            pc_next = PC_SINGLE;
                        end
                    end
                    else if (mode_reg == MODE_UNDECIDED)
                        pc_next = PC_SINGLE;
                    else if (pc_reg == PC_SINGLE)
                    begin
                        if (gap_reg != GAP_NONE) fail_next = 1'b1;
                        else
                        begin
                            gap_next = gcnt_reg; pc_next = PC_DOUBLE;
                        end
                    end
                    else
                        fail_next = 1'b1;
                end
                else
                    fail_next = 1'b1;
            end
            else
                fail_next = 1'b1;
        end

        // Verdict on the state after this character.
        fin_ok = !fail_next && (mode_next != MODE_UNDECIDED);
        for (int k = 0; k < 8; k++) g[k] = grp_next[k];
        fcnt = gcnt_next;
        o3 = dec_next[7:0];
        for (int k = 0; k < 8; k++) fg[k] = '0;
        if (mode_next == MODE_V4 || mode_next == MODE_TAIL)
        begin
            if (oidx_next != 3'd3 || !oct_ok(run_next, let_next, dec_next, rz_next))
                fin_ok = 1'b0;
            if (mode_next == MODE_TAIL)
            begin
                if (fcnt > 4'd6) fin_ok = 1'b0;
                else
                begin
                    g[fcnt[2:0]] = {oct_next[0], oct_next[1]};
                    g[3'(fcnt[2:0] + 3'd1)] = {oct_next[2], o3};
                    fcnt = fcnt + 4'd2;
                end
            end
        end
        else if (run_next != 2'd0)
        begin
            if (hex_next > 17'hFFFF || fcnt >= 4'd8) fin_ok = 1'b0;
            else
            begin
                g[fcnt[2:0]] = hex_next[15:0];
                fcnt = fcnt + 4'd1;
            end
        end
        else if (pc_next != PC_DOUBLE)
            fin_ok = 1'b0;
        if (mode_next != MODE_V4)
        begin
            if (fcnt < 4'd8 && gap_next == GAP_NONE) fin_ok = 1'b0;
            if (fcnt >= 4'd8 && gap_next != GAP_NONE) fin_ok = 1'b0;
        end
        shift = 4'd8 - fcnt;
        for (int k = 0; k < 8; k++)
        begin
            src = 4'(k) - shift;
            if (mode_next == MODE_V4)
                fg[k] = (k == 5) ? 16'hFFFF :
                        (k == 6) ? {oct_next[0], oct_next[1]} :
                        (k == 7) ? {oct_next[2], o3} : 16'h0;
            else if (gap_next == GAP_NONE || 4'(k) < gap_next)
                fg[k] = g[k];
            else if (4'(k) >= gap_next + shift && src < fcnt)
                fg[k] = g[src[2:0]];
        end
        res_next.valid_res = fin_ok;
        res_next.is_v6 = (mode_next == MODE_V6 || mode_next == MODE_TAIL);
        res_next.addr_hi = fin_ok ? {fg[0], fg[1], fg[2], fg[3]} : 64'h0;
        res_next.addr_lo = fin_ok ? {fg[4], fg[5], fg[6], fg[7]} : 64'h0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gcnt_reg <= '0; gap_reg <= GAP_NONE; hex_reg <= '0; dec_reg <= '0;
            run_reg <= '0; rz_reg <= 1'b0; let_reg <= 1'b0; oidx_reg <= '0;
            mode_reg <= MODE_UNDECIDED; pc_reg <= PC_NONE; fail_reg <= 1'b0;
            ovld_reg <= 1'b0;
            for (int k = 0; k < 8; k++) grp_reg[k] <= '0;
            for (int k = 0; k < 3; k++) oct_reg[k] <= '0;
        end
        else
        begin
            if (take && cls.last)
                ovld_reg <= 1'b1;
            else if (!out_stall)
                ovld_reg <= 1'b0;
            if (take)
            begin
                if (cls.last)
                begin
                    gcnt_reg <= '0; gap_reg <= GAP_NONE; hex_reg <= '0; dec_reg <= '0;
                    run_reg <= '0; rz_reg <= 1'b0; let_reg <= 1'b0; oidx_reg <= '0;
                    mode_reg <= MODE_UNDECIDED; pc_reg <= PC_NONE; fail_reg <= 1'b0;
                    for (int k = 0; k < 8; k++) grp_reg[k] <= '0;
                    for (int k = 0; k < 3; k++) oct_reg[k] <= '0;
                end
                else
                begin
                    gcnt_reg <= gcnt_next; gap_reg <= gap_next; hex_reg <= hex_next;
                    dec_reg <= dec_next; run_reg <= run_next; rz_reg <= rz_next;
                    let_reg <= let_next; oidx_reg <= oidx_next; mode_reg <= mode_next;
                    pc_reg <= pc_next; fail_reg <= fail_next;
                    for (int k = 0; k < 8; k++) grp_reg[k] <= grp_next[k];
                    for (int k = 0; k < 3; k++) oct_reg[k] <= oct_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && cls.last)
            res_reg <= res_next;
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) gcnt_reg <= 4'd8)
        else $error("group count overflow");
    a_oidx: assert property (@(posedge clk) disable iff (!rst_n) oidx_reg <= 3'd3)
        else $error("octet index overflow");
    a_clr: assert property (@(posedge clk) disable iff (!rst_n)
        take && cls.last |=> mode_reg == MODE_UNDECIDED && !fail_reg)
        else $error("state not cleared after last");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg && !res_reg.valid_res |-> res_reg.addr_hi == 64'h0 && res_reg.addr_lo == 64'h0)
        else $error("invalid result carries address");
endmodule

/* tb/sv/testbench.sv */
// Testbench for ip_address_text_validator: drives address text one character per item
// and checks each verdict against a built-in parser model. Depends on ipv_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import ipv_pkg::*;

    // Expected-verdict store: tracks parse state per string, queues verdicts.
    class addr_scoreboard;
        logic [15:0] groups [8];
        int unsigned ngroups;
        int unsigned gap_at;
        int unsigned hexv;
        int unsigned decv;
        int unsigned ndig;
        bit lead_zero;
        bit has_letter;
        logic [7:0] octets [4];
        int unsigned noct;
        mode_t mode;
        colon_t colon;
        bit bad;
        out_item_t verdicts [$];
        int errors;

        function new();
            errors = 0;
            clear_string();
        endfunction

        function void clear_token();
            hexv = 0;
            decv = 0;
            ndig = 0;
            lead_zero = 0;
            has_letter = 0;
        endfunction

        function void clear_string();
            for (int k = 0; k < 8; k++) groups[k] = '0;
            for (int k = 0; k < 4; k++) octets[k] = '0;
            ngroups = 0;
            gap_at = GAP_NONE;
            clear_token();
            noct = 0;
            mode = MODE_UNDECIDED;
            colon = PC_NONE;
            bad = 0;
        endfunction

        function bit octet_good();
            if (ndig == 0 || has_letter) return 0;
            if (decv > 255) return 0;
            if (ndig > 1 && lead_zero) return 0;
            return 1;
        endfunction

        function bit close_group();
            if (ndig == 0 || hexv > 16'hFFFF || ngroups >= 8) return 0;
            groups[ngroups] = hexv[15:0];
            ngroups++;
            clear_token();
            return 1;
        endfunction

        function void take_char(logic [7:0] c);
            bit dec;
            bit hx;
            int unsigned v;
            dec = (c >= "0" && c <= "9");
            hx = dec || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
            v = 0;
            if (hx) begin
                if (dec) v = c - "0";
                else if (c >= "a") v = c - "a" + 10;
                else v = c - "A" + 10;
                if (mode == MODE_V4 || mode == MODE_TAIL) begin
                    if (!dec) begin bad = 1; return; end
                end
                else if (mode == MODE_V6) begin
                    if (ngroups >= 8) begin bad = 1; return; end
                    // lone leading colon
                    if (colon == PC_SINGLE && ngroups == 0 && gap_at == GAP_NONE) begin
                        bad = 1;
                        return;
                    end
                    colon = PC_NONE;
                end
                if (ndig == 0) lead_zero = (c == "0");
                if (ndig < 3) ndig++;
                hexv = hexv * 16 + v;
                if (hexv > 32'h10000) hexv = 32'h10000;
                if (dec) begin
                    decv = decv * 10 + v;
                    if (decv > 256) decv = 256;
                end
                else has_letter = 1;
                return;
            end
            if (c == ".") begin
                if (mode == MODE_UNDECIDED) begin
                    if (!octet_good()) begin bad = 1; return; end
                    octets[0] = decv[7:0];
                    noct = 1;
                    mode = MODE_V4;
                end
                else if (mode == MODE_V6) begin
                    if (ndig == 0 || hexv > 16'hFFFF) begin bad = 1; return; end
                    if (gap_at == GAP_NONE && ngroups != 6) begin bad = 1; return; end
                    if (ngroups > 6 || !octet_good()) begin bad = 1; return; end
                    octets[0] = decv[7:0];
                    noct = 1;
                    mode = MODE_TAIL;
                end
                else begin
                    if (!octet_good() || noct >= 3) begin bad = 1; return; end
                    octets[noct] = decv[7:0];
                    noct++;
                end
                clear_token();
                return;
            end
            if (c == ":") begin
                if (mode == MODE_UNDECIDED) begin
                    mode = MODE_V6;
                    if (ndig > 0 && !close_group()) begin bad = 1; return; end
                    colon = PC_SINGLE;
                end
                else if (mode == MODE_V6) begin
                    if (ndig > 0) begin
                        if (!close_group()) begin bad = 1; return; end
                        colon = PC_SINGLE;
                    end
                    else if (colon == PC_SINGLE) begin
                        if (gap_at != GAP_NONE) begin bad = 1; return; end
                        gap_at = ngroups;
                        colon = PC_DOUBLE;
                    end
                    else bad = 1;
                end
                else bad = 1;
                return;
            end
            bad = 1;
        endfunction

        function bit verdict(output logic [15:0] g [8]);
            int unsigned shift;
            for (int k = 0; k < 8; k++) g[k] = '0;
            if (bad || mode == MODE_UNDECIDED) return 0;
            if (mode == MODE_V4 || mode == MODE_TAIL) begin
                if (noct != 3 || !octet_good()) return 0;
                octets[3] = decv[7:0];
                if (mode == MODE_V4) begin
                    g[5] = 16'hFFFF;
                    g[6] = {octets[0], octets[1]};
                    g[7] = {octets[2], octets[3]};
                    return 1;
                end
                if (ngroups > 6) return 0;
                groups[ngroups] = {octets[0], octets[1]};
                groups[ngroups + 1] = {octets[2], octets[3]};
                ngroups += 2;
            end
            else if (ndig > 0) begin
                if (!close_group()) return 0;
            end
            else if (colon != PC_DOUBLE) return 0;
            if (ngroups < 8) begin
                if (gap_at == GAP_NONE) return 0;
            end
            else if (gap_at != GAP_NONE) return 0;
            if (gap_at == GAP_NONE) begin
                for (int k = 0; k < 8; k++) g[k] = groups[k];
            end
            else begin
                shift = 8 - ngroups;
                for (int k = 0; k < gap_at && k < 8; k++) g[k] = groups[k];
                for (int k = gap_at; k < ngroups && k < 8; k++) g[(k + shift) % 8] = groups[k];
            end
            return 1;
        endfunction

        // Note an accepted input item; queue a verdict on the last character.
        function void note_input(in_item_t it);
            logic [15:0] g [8];
            out_item_t r;
            if (!bad) take_char(it.ch);
            if (!it.last) return;
            r = '0;
            r.valid_res = verdict(g);
            r.is_v6 = (mode == MODE_V6 || mode == MODE_TAIL);
            if (r.valid_res) begin
                r.addr_hi = {g[0], g[1], g[2], g[3]};
                r.addr_lo = {g[4], g[5], g[6], g[7]};
            end
            verdicts.push_back(r);
            clear_string();
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (verdicts.size() == 0) begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            if (got.valid_res !== want.valid_res) begin
                $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
                errors++;
            end
            if (got.is_v6 !== want.is_v6) begin
                $error("is_v6: expected %0d, got %0d", want.is_v6, got.is_v6);
                errors++;
            end
            if (got.addr_hi !== want.addr_hi) begin
                $error("addr_hi: expected %h, got %h", want.addr_hi, got.addr_hi);
                errors++;
            end
            if (got.addr_lo !== want.addr_lo) begin
                $error("addr_lo: expected %h, got %h", want.addr_lo, got.addr_lo);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    in_item_t  in_item;
    logic      in_valid;
    logic      in_stall;
    out_item_t out_item;
    logic      out_valid;
    logic      out_stall;

    addr_scoreboard sb;
    int send_idle_pct;     // chance in 100 that the sender idles a cycle
    int recv_stall_pct;    // chance in 100 that the receiver stalls a cycle
    int hold_off_cycles;   // when nonzero, the receiver stalls this many cycles
    int items_sent;

    ip_address_text_validator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Receiver: stall at random, or hold off for a counted stretch when asked.
    // Check every item accepted at the edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_item);
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_stall <= 1'b1;
            end
            else out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Send one item: hold it until accepted, idle at random before it.
    task automatic send_char(input logic [7:0] c, input logic l);
        in_item_t it;
        it.ch = c;
        it.last = l;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
    endtask

    // Drop valid and wait until every queued verdict has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.verdicts.size() != 0) @(posedge clk);
    endtask

    function automatic string hex_group();
        string s;
        string digits;
        int n;
        digits = "0123456789abcdefABCDEF";
        n = $urandom_range(4, 1);
        if ($urandom_range(19) == 0) n = 5;
        s = "";
        for (int k = 0; k < n; k++) s = {s, string'(digits[$urandom_range(21)])};
        return s;
    endfunction

    function automatic string dec_octet();
        int r;
        r = $urandom_range(9);
        if (r == 0) return $sformatf("0%0d", $urandom_range(9));
        if (r == 1) return $sformatf("%0d", $urandom_range(999, 256));
        return $sformatf("%0d", $urandom_range(255));
    endfunction

    function automatic string v4_text();
        return $sformatf("%s.%s.%s.%s", dec_octet(), dec_octet(), dec_octet(), dec_octet());
    endfunction

    function automatic string v6_text();
        string s;
        int n;
        int gap;
        bit tail;
        tail = ($urandom_range(4) == 0);
        gap = ($urandom_range(2) == 0) ? -1 : $urandom_range(7);
        n = tail ? 6 : 8;
        if (gap >= 0) n = $urandom_range(n - 1);
        if ($urandom_range(15) == 0) n = n + 1;
        s = "";
        for (int k = 0; k < n; k++) begin
            if (k == gap) s = {s, "::"};
            else if (k > 0) s = {s, ":"};
            s = {s, hex_group()};
        end
        if (gap >= n) s = {s, "::"};
        if (tail) s = {s, (s.len() == 0 || s[s.len() - 1] == ":") ? "" : ":", v4_text()};
        return s;
    endfunction

    // Mutate a generated string: replace one character with any byte.
    function automatic string broken(input string s);
        int p;
        p = $urandom_range(s.len() - 1);
        s[p] = $urandom_range(255);
        return s;
    endfunction

    task automatic random_phase(input int n_items);
        int start;
        int r;
        string s;
        start = items_sent;
        while (items_sent - start < n_items) begin
            r = $urandom_range(9);
            if (r < 4) s = v6_text();
            else if (r < 7) s = v4_text();
            else if (r < 9) s = broken(($urandom_range(1) == 0) ? v6_text() : v4_text());
            else begin
                s = "";
                for (int k = $urandom_range(6, 1); k > 0; k--) s = {s, string'(8'($urandom()))};
            end
            if (s.len() == 0) s = "::";
            send_text(s);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        items_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every form and the named special cases.
        send_text("255.255.255.255");
        send_text("0.0.0.0");
        send_text("01.2.3.4");
        send_text("256.1.1.1");
        send_text("1.2.3");
        send_text("FFFF:ffff:0:1:2:3:4:5");
        send_text("::");
        send_text("::1.2.3.4");
        send_text(":1::2");
        send_text("1:2:3:4:5:6:1.2.3.4");
        send_text("12345::1");
        send_text("abc");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("1::2::3");
        send_text("1:2:3:4:5:6:7:8:9");
        drain();

        // Phases of idling and stalling, a long receiver hold-off with the sender busy, a mixed phase.
        random_phase(150);
        send_idle_pct = 68;
        random_phase(120);
        send_idle_pct = 0;
        recv_stall_pct = 68;
        random_phase(120);
        send_idle_pct = 9;
        recv_stall_pct = 9;
        random_phase(120);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 200;
        random_phase(50);
        drain();
        send_idle_pct = 30;
        recv_stall_pct = 30;
        random_phase(90);
        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.verdicts.size() == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

/* files.f */
rtl/ipv_pkg.sv
rtl/ipv_front.sv
rtl/ipv_queue.sv
rtl/ipv_back.sv
rtl/ip_address_text_validator.sv
tb/sv/testbench.sv
